// ===== rtl/trra_pkg.sv =====
// Shared types, widths, codes and helper function of the tile rotate resample address unit.
`default_nettype none

package trra_pkg;

   // Upper bound that every size is saturated to before use.
   localparam int MAX_DIM = 4096;

   // Field widths fixed by the interface.
   localparam int CW   = 12;          // pixel and origin coordinates
   localparam int SZW  = 13;          // sizes: tile, image and texture
   localparam int OFW  = 26;          // byte offsets
   localparam int QW   = SZW;         // quotient bits, one per divider cell
   localparam int DVW  = SZW + QW;    // dividend and remainder width
   localparam int CSR_IW = 2;         // configuration register index width

   // Configuration register indexes.
   localparam logic [CSR_IW-1:0] REG_TILE_SIZE   = 2'd0;
   localparam logic [CSR_IW-1:0] REG_IMAGE_WIDTH = 2'd1;

   // Quarter-turn codes.
   localparam logic [1:0] TURN_0   = 2'd0;
   localparam logic [1:0] TURN_90  = 2'd1;
   localparam logic [1:0] TURN_180 = 2'd2;
   localparam logic [1:0] TURN_270 = 2'd3;

   typedef struct packed {
      logic [CW-1:0]  pixel_x;
      logic [CW-1:0]  pixel_y;
      logic [CW-1:0]  origin_x;
      logic [CW-1:0]  origin_y;
      logic [1:0]     turn;
      logic [SZW-1:0] texture_width;
      logic [SZW-1:0] texture_height;
      logic           texture_missing;
   } req_type;

   typedef struct packed {
      logic [OFW-1:0] dest_offset;
      logic [OFW-1:0] src_offset;
      logic           use_fill;
      logic           fill_light;
   } rsp_type;

   // Work carried from cell to cell down the divider chain.
   typedef struct packed {
      logic [DVW-1:0] rem_x;
      logic [DVW-1:0] rem_y;
      logic [DVW-1:0] dsh;
      logic [QW-1:0]  q_x;
      logic [QW-1:0]  q_y;
      logic [SZW-1:0] tw;
      logic [SZW-1:0] th;
      logic [OFW-1:0] dest;
      logic           missing;
   } cell_type;

   // Saturates a size to the range 1 to MAX_DIM.
   function automatic logic [SZW-1:0] sat_size(input logic [SZW-1:0] v);
      logic [SZW-1:0] r;
      if (v == '0) begin
         r = SZW'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = SZW'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tile_rotate_resample_address_unit.sv =====
// Top level of the tile rotate resample address unit: registers, front stage, divider chain, output.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_ready    req_payload (trra_pkg::req_type)
//   rsp       out        rsp_valid/rsp_ready    rsp_payload (trra_pkg::rsp_type)
//   csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One request per cycle while no stall holds the stages; a response passes through, in order,
// one front stage, a chain of 13 divider cells (one quotient bit per cell) and an output stage.
// Every stage has its own valid bit and advances when the stage after it is empty or
// moving, so bubbles close up and a stalled response does not stop upstream stages that
// still have room. Reset clears all stage valid bits and sets both registers to one.
// The configuration port is always ready; registers are meant to change only while idle.
`default_nettype none

module tile_rotate_resample_address_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire trra_pkg::req_type          req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output trra_pkg::rsp_type               rsp_payload,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [trra_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [trra_pkg::SZW-1:0]   csr_data
);
   import trra_pkg::*;

   logic [SZW-1:0] tile_size_ff;
   logic [SZW-1:0] image_width_ff;

   // Chain links: link 0 leaves the front stage, link k+1 leaves cell k.
   cell_type       link_data  [QW+1];
   logic           link_valid [QW+1];
   logic           link_ready [QW+1];

   assign csr_ready = 1'b1;

   // Register writes to an index outside the map are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff   <= SZW'(1);
         image_width_ff <= SZW'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TILE_SIZE: begin
               tile_size_ff <= csr_data;
            end
            REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Saturation, clamp and rotation happen here, along with both scale products and
   // the destination offset. A missing texture swaps in the pixel coordinates as
   // dividends and the checker cell edge as divisor, so one chain serves both cases.
   trra_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_req      (req_payload),
      .tile_size   (tile_size_ff),
      .image_width (image_width_ff),
      .out_valid   (link_valid[0]),
      .out_ready   (link_ready[0]),
      .out_data    (link_data[0])
   );

   for (genvar k = 0; k < QW; k++) begin : g_cell
      trra_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   // The output stage is the response register; it holds its value while rsp_ready is low.
   trra_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[QW]),
      .in_ready  (link_ready[QW]),
      .in_data   (link_data[QW]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== rtl/trra_prep.sv =====
// Front stage: size saturation, clamp, rotation, scale products and destination offset.
`default_nettype none

module trra_prep (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire trra_pkg::req_type       in_req,
   input  wire logic [trra_pkg::SZW-1:0] tile_size,
   input  wire logic [trra_pkg::SZW-1:0] image_width,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output trra_pkg::cell_type           out_data
);
   import trra_pkg::*;

   logic           valid_ff;
   cell_type       data_ff;
   cell_type       data_in;

   logic [SZW-1:0] e;
   logic [SZW-1:0] em1;
   logic [SZW-1:0] iw;
   logic [SZW-1:0] tw;
   logic [SZW-1:0] th;
   logic [SZW-1:0] cx;
   logic [SZW-1:0] cy;
   logic [SZW-1:0] ox;
   logic [SZW-1:0] oy;
   logic [SZW-1:0] square_edge;
   logic [SZW-1:0] divisor;
   logic [SZW-1:0] row;
   logic [SZW-1:0] col;
   logic [DVW-1:0] prod_x;
   logic [DVW-1:0] prod_y;
   logic [OFW-1:0] lin;

   always_comb begin
      e   = sat_size(tile_size);
      em1 = e - SZW'(1);
      iw  = sat_size(image_width);
      tw  = sat_size(in_req.texture_width);
      th  = sat_size(in_req.texture_height);

      // Coordinates past the tile edge are pinned to the last pixel for sampling.
      cx = (SZW'(in_req.pixel_x) > em1) ? em1 : SZW'(in_req.pixel_x);
      cy = (SZW'(in_req.pixel_y) > em1) ? em1 : SZW'(in_req.pixel_y);

      case (in_req.turn)
         TURN_90: begin
            ox = em1 - cy;
            oy = cx;
         end
         TURN_180: begin
            ox = em1 - cx;
            oy = em1 - cy;
         end
         TURN_270: begin
            ox = cy;
            oy = em1 - cx;
         end
         default: begin
            ox = cx;
            oy = cy;
         end
      endcase

      prod_x = DVW'(ox) * DVW'(tw);
      prod_y = DVW'(oy) * DVW'(th);

      // Checker cell edge is a quarter of the tile, never below one pixel.
      square_edge = ((e >> 2) == '0) ? SZW'(1) : (e >> 2);
      divisor     = in_req.texture_missing ? square_edge : e;

      row = SZW'(in_req.origin_y) + SZW'(in_req.pixel_y);
      col = SZW'(in_req.origin_x) + SZW'(in_req.pixel_x);
      lin = OFW'(DVW'(row) * DVW'(iw)) + OFW'(col);

      data_in.rem_x   = in_req.texture_missing ? DVW'(in_req.pixel_x) : prod_x;
      data_in.rem_y   = in_req.texture_missing ? DVW'(in_req.pixel_y) : prod_y;
      data_in.dsh     = DVW'(divisor) << (QW - 1);
      data_in.q_x     = '0;
      data_in.q_y     = '0;
      data_in.tw      = tw;
      data_in.th      = th;
      data_in.dest    = {lin[OFW-3:0], 2'b00};
      data_in.missing = in_req.texture_missing;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/trra_cell.sv =====
// One restoring divider cell: resolves one quotient bit on both coordinate lanes.
`default_nettype none

module trra_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire trra_pkg::cell_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output trra_pkg::cell_type      out_data
);
   import trra_pkg::*;

   logic     valid_ff;
   cell_type data_ff;
   cell_type data_in;
   logic     ge_x;
   logic     ge_y;

   always_comb begin
      ge_x = in_data.rem_x >= in_data.dsh;
      ge_y = in_data.rem_y >= in_data.dsh;

      data_in       = in_data;
      data_in.rem_x = ge_x ? in_data.rem_x - in_data.dsh : in_data.rem_x;
      data_in.rem_y = ge_y ? in_data.rem_y - in_data.dsh : in_data.rem_y;
      data_in.q_x   = {in_data.q_x[QW-2:0], ge_x};
      data_in.q_y   = {in_data.q_y[QW-2:0], ge_y};
      // The next cell tries the divisor one bit position lower.
      data_in.dsh   = in_data.dsh >> 1;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/trra_finish.sv =====
// Output stage: clamps the scaled coordinates, forms the source offset and holds the response.
`default_nettype none

module trra_finish (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire trra_pkg::cell_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output trra_pkg::rsp_type       out_rsp
);
   import trra_pkg::*;

   logic           valid_ff;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;
   logic [SZW-1:0] tw_m1;
   logic [SZW-1:0] th_m1;
   logic [SZW-1:0] sx;
   logic [SZW-1:0] sy;
   logic [OFW-1:0] lin;

   always_comb begin
      tw_m1 = in_data.tw - SZW'(1);
      th_m1 = in_data.th - SZW'(1);
      sx    = (in_data.q_x > tw_m1) ? tw_m1 : in_data.q_x;
      sy    = (in_data.q_y > th_m1) ? th_m1 : in_data.q_y;
      lin   = OFW'(DVW'(sy) * DVW'(in_data.tw)) + OFW'(sx);

      rsp_in.dest_offset = in_data.dest;
      rsp_in.use_fill    = in_data.missing;
      if (in_data.missing) begin
         rsp_in.src_offset = '0;
         rsp_in.fill_light = in_data.q_x[0] ^ in_data.q_y[0];
      end else begin
         rsp_in.src_offset = {lin[OFW-3:0], 2'b00};
         rsp_in.fill_light = 1'b0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/trra_checker.sv =====
// Port checker for the tile rotate resample address unit and its bind statement.
`default_nettype none

module trra_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire trra_pkg::rsp_type rsp_payload
);
   import trra_pkg::*;

   // No response may appear right after a reset cycle.
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response stays up and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response dropped or changed");

   // Fill responses never carry a source address, copies never pick a checker color.
   a_fill_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.use_fill ? rsp_payload.src_offset == '0
                                          : !rsp_payload.fill_light))
      else $error("fill and copy fields mixed");

   // Both offsets address whole four-byte pixels.
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.dest_offset[1:0] == 2'b00
                 && rsp_payload.src_offset[1:0] == 2'b00)
      else $error("offset not pixel aligned");

endmodule

bind tile_rotate_resample_address_unit trra_checker u_trra_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
